FILE: rtl/core/first_fit_unit_allocator_assert.svh
// ----------------------------------------------------------------------------
// First-fit unit allocator assertion macros
// Concurrent checks on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_UNIT_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_UNIT_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
// expression must hold at every edge
`define FFUA_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("ffua: invariant violated");
// consequent must hold in the same cycle
`define FFUA_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ffua: implication violated");
// consequent must hold in the next cycle
`define FFUA_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ffua: sequence violated");
`else
`define FFUA_ALWAYS(lbl, expr)
`define FFUA_IMPL(lbl, ante, cons)
`define FFUA_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/core/ffua_pkg.sv
// ----------------------------------------------------------------------------
// ffua_pkg
// Shared constants, command codes and status struct of the allocator.
// ----------------------------------------------------------------------------
package ffua_pkg;

	// arena geometry
	localparam int ARENA_UNITS = 2048;
	localparam int AW = $clog2(ARENA_UNITS);          // header word index
	localparam int XW = $clog2(ARENA_UNITS + 4097);   // offsets past the arena
	localparam int CW = $clog2(ARENA_UNITS + 1);      // free count / next link
	localparam int SW = 17;                           // block sizes and sums
	localparam int WW = 16;                           // header word

	typedef logic [XW-1:0] xaddr_t;
	typedef logic [4:0]    cmd_t;

	// datapath commands
	localparam cmd_t C_NOP       = 5'd0;
	localparam cmd_t C_CLEAR     = 5'd1;
	localparam cmd_t C_LOAD      = 5'd2;
	localparam cmd_t C_RD        = 5'd3;
	localparam cmd_t C_W0        = 5'd4;
	localparam cmd_t C_W1        = 5'd5;
	localparam cmd_t C_WR_A      = 5'd6;
	localparam cmd_t C_WR_B      = 5'd7;
	localparam cmd_t C_A_START   = 5'd8;
	localparam cmd_t C_A_STEP    = 5'd9;
	localparam cmd_t C_A_HIT     = 5'd10;
	localparam cmd_t C_A_SPLIT   = 5'd11;
	localparam cmd_t C_FAIL      = 5'd12;
	localparam cmd_t C_WHOLE     = 5'd13;
	localparam cmd_t C_F_START   = 5'd14;
	localparam cmd_t C_FH_MERGE  = 5'd15;
	localparam cmd_t C_FH_PLAIN  = 5'd16;
	localparam cmd_t C_W_STEP    = 5'd17;
	localparam cmd_t C_W_END     = 5'd18;
	localparam cmd_t C_N_MERGE   = 5'd19;
	localparam cmd_t C_P_REFETCH = 5'd20;
	localparam cmd_t C_P_SAVE    = 5'd21;
	localparam cmd_t C_P_MERGE   = 5'd22;
	localparam cmd_t C_P_PLAIN   = 5'd23;
	localparam cmd_t C_PUSH      = 5'd24;

	// datapath status toward the controller
	typedef struct packed {
		logic clr_done;
		logic is_free;
		logic w0_pos;
		logic a_nofit;
		logic fit;
		logic exact;
		logic fn_end;
		logic has_prev;
		logic whole;
		logic b_lt_head;
		logic head_merge;
		logic b_gt_fn;
		logic next_merge;
		logic prev_adj;
		logic ws_big;
		logic out_free;
	} ffua_stat_t;

endpackage

FILE: rtl/core/first_fit_unit_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_unit_allocator
// First-fit allocator over an arena of 2-byte units, free list in the arena.
// ----------------------------------------------------------------------------
//  channel  dir  bus                     content
//  s_*      in   tdata[23:0], tuser[0]   size_bytes, block_unit / op
//  m_*      out  tdata[23:0], tuser[0]   alloc_unit, units_left / status
//
//  Each beat passes the take, decode and result states, plus a fetch of
//  one or two header words per free block visited, a store of one or two
//  header words per block header written, and bookkeeping steps on most
//  paths (split check, fail, plain head insert, refetch of the previous
//  block on a free). The list walk sets how long a beat takes.
//  After reset a clearing sweep writes every word of the header RAM;
//  s_tready stays low meanwhile.
//  The result register frees the input: a new beat is taken while a result
//  waits, and the next result holds until m_tready takes the last one.
// ----------------------------------------------------------------------------
module first_fit_unit_allocator
	import ffua_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [12:0] size_bytes, [23:13] block_unit
	input  logic [0:0]  s_tuser,   // [0] op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [10:0] alloc_unit, [22:11] units_left, [23] zero
	output logic [0:0]  m_tuser    // [0] status
);

	ffua_stat_t  st;
	cmd_t        cmd;
	logic        out_status;
	logic [10:0] out_unit;
	logic [11:0] out_left;

	ffua_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.st       (st),
		.in_ready (s_tready),
		.cmd      (cmd)
	);

	ffua_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.in_op      (s_tuser[0]),
		.in_size    (s_tdata[12:0]),
		.in_block   (s_tdata[23:13]),
		.out_ready  (m_tready),
		.st         (st),
		.out_valid  (m_tvalid),
		.out_status (out_status),
		.out_unit   (out_unit),
		.out_left   (out_left)
	);

	// result packing
	assign m_tdata = {1'b0, out_left, out_unit};
	assign m_tuser = out_status;

endmodule

FILE: rtl/core/ffua_ram.sv
// ----------------------------------------------------------------------------
// ffua_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffua_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/core/ffua_ctrl.sv
// ----------------------------------------------------------------------------
// ffua_ctrl
// Sequencer: list walks, block fetch and block store subroutines.
// ----------------------------------------------------------------------------
`include "first_fit_unit_allocator_assert.svh"

module ffua_ctrl
	import ffua_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  ffua_stat_t st,
	output logic       in_ready,
	output cmd_t       cmd
);

	localparam logic [4:0] S_CLR   = 5'd0;
	localparam logic [4:0] S_IDLE  = 5'd1;
	localparam logic [4:0] S_DEC   = 5'd2;
	localparam logic [4:0] S_FA    = 5'd3;
	localparam logic [4:0] S_FB    = 5'd4;
	localparam logic [4:0] S_FC    = 5'd5;
	localparam logic [4:0] S_WA    = 5'd6;
	localparam logic [4:0] S_WB    = 5'd7;
	localparam logic [4:0] S_A_CHK = 5'd8;
	localparam logic [4:0] S_A_SPL = 5'd9;
	localparam logic [4:0] S_FAIL  = 5'd10;
	localparam logic [4:0] S_FH_M  = 5'd11;
	localparam logic [4:0] S_FH_P  = 5'd12;
	localparam logic [4:0] S_W_CHK = 5'd13;
	localparam logic [4:0] S_N_M   = 5'd14;
	localparam logic [4:0] S_P_RF  = 5'd15;
	localparam logic [4:0] S_P_CHK = 5'd16;
	localparam logic [4:0] S_P_M   = 5'd17;
	localparam logic [4:0] S_DONE  = 5'd18;

	logic [4:0] state_q, state_d;
	logic [4:0] ret_q, ret_d;

	// next state and command
	always_comb begin
		state_d  = state_q;
		ret_d    = ret_q;
		cmd      = C_NOP;
		in_ready = 1'b0;
		case (state_q)
			S_CLR: begin
				cmd = C_CLEAR;
				if (st.clr_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd     = C_LOAD;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				if (!st.is_free) begin
					if (st.a_nofit) begin
						state_d = S_FAIL;
					end else begin
						cmd     = C_A_START;
						ret_d   = S_A_CHK;
						state_d = S_FA;
					end
				end else if (st.whole) begin
					cmd     = C_WHOLE;
					ret_d   = S_DONE;
					state_d = S_WA;
				end else begin
					cmd = C_F_START;
					if (st.b_lt_head) begin
						if (st.head_merge) begin
							ret_d   = S_FH_M;
							state_d = S_FA;
						end else begin
							state_d = S_FH_P;
						end
					end else begin
						ret_d   = S_W_CHK;
						state_d = S_FA;
					end
				end
			end
			// block fetch: word s, then word s+1 for multi-unit blocks
			S_FA: begin
				cmd     = C_RD;
				state_d = S_FB;
			end
			S_FB: begin
				cmd     = C_W0;
				state_d = st.w0_pos ? S_FC : ret_q;
			end
			S_FC: begin
				cmd     = C_W1;
				state_d = ret_q;
			end
			// block store: one or two header words
			S_WA: begin
				cmd     = C_WR_A;
				state_d = st.ws_big ? S_WB : ret_q;
			end
			S_WB: begin
				cmd     = C_WR_B;
				state_d = ret_q;
			end
			S_A_CHK: begin
				if (st.fit) begin
					cmd     = C_A_HIT;
					ret_d   = S_A_SPL;
					state_d = st.has_prev ? S_WA : S_A_SPL;
				end else begin
					cmd = C_A_STEP;
					if (st.fn_end) begin
						state_d = S_FAIL;
					end else begin
						ret_d   = S_A_CHK;
						state_d = S_FA;
					end
				end
			end
			S_A_SPL: begin
				if (st.exact) begin
					state_d = S_DONE;
				end else begin
					cmd     = C_A_SPLIT;
					ret_d   = S_DONE;
					state_d = S_WA;
				end
			end
			S_FAIL: begin
				cmd     = C_FAIL;
				state_d = S_DONE;
			end
			S_FH_M: begin
				cmd     = C_FH_MERGE;
				ret_d   = S_DONE;
				state_d = S_WA;
			end
			S_FH_P: begin
				cmd     = C_FH_PLAIN;
				ret_d   = S_DONE;
				state_d = S_WA;
			end
			S_W_CHK: begin
				if (st.b_gt_fn) begin
					cmd     = C_W_STEP;
					ret_d   = S_W_CHK;
					state_d = S_FA;
				end else begin
					cmd = C_W_END;
					if (st.next_merge) begin
						ret_d   = S_N_M;
						state_d = S_FA;
					end else begin
						ret_d   = S_P_RF;
						state_d = S_WA;
					end
				end
			end
			S_N_M: begin
				cmd     = C_N_MERGE;
				ret_d   = S_P_RF;
				state_d = S_WA;
			end
			S_P_RF: begin
				cmd     = C_P_REFETCH;
				ret_d   = S_P_CHK;
				state_d = S_FA;
			end
			S_P_CHK: begin
				if (st.prev_adj) begin
					cmd     = C_P_SAVE;
					ret_d   = S_P_M;
					state_d = S_FA;
				end else begin
					cmd     = C_P_PLAIN;
					ret_d   = S_DONE;
					state_d = S_WA;
				end
			end
			S_P_M: begin
				cmd     = C_P_MERGE;
				ret_d   = S_DONE;
				state_d = S_WA;
			end
			S_DONE: begin
				if (st.out_free) begin
					cmd     = C_PUSH;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			ret_q   <= S_IDLE;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end

	`FFUA_NEXT(a_fetch_order, state_q == S_FA, state_q == S_FB)
	`FFUA_NEXT(a_clear_holds, (state_q == S_CLR) && !st.clr_done, state_q == S_CLR)
	`FFUA_NEXT(a_done_to_idle, (state_q == S_DONE) && st.out_free, state_q == S_IDLE)

endmodule

FILE: rtl/core/ffua_dp.sv
// ----------------------------------------------------------------------------
// ffua_dp
// Datapath: header RAM, list pointers, counters, compares, result register.
// ----------------------------------------------------------------------------
`include "first_fit_unit_allocator_assert.svh"

module ffua_dp
	import ffua_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  cmd_t          cmd,
	input  logic          in_op,
	input  logic [12:0]   in_size,
	input  logic [10:0]   in_block,
	input  logic          out_ready,
	output ffua_stat_t    st,
	output logic          out_valid,
	output logic          out_status,
	output logic [10:0]   out_unit,
	output logic [11:0]   out_left
);

	localparam xaddr_t END_X = xaddr_t'(ARENA_UNITS);

	// request and list state
	logic          op_q;
	logic [12:0]   units_q;
	logic [10:0]   b_q;
	xaddr_t        head_q;
	logic [CW-1:0] count_q;
	xaddr_t        cur_q;
	logic [14:0]   fu_q;
	logic [CW-1:0] fn_q;
	logic [CW-1:0] prev_q;
	logic [14:0]   pu_q;
	logic          has_prev_q;
	logic [SW-1:0] size_q;
	xaddr_t        ws_addr_q;
	logic [SW-1:0] ws_size_q;
	xaddr_t        ws_next_q;
	logic [AW-1:0] clr_q;
	logic          rd_oob_q;
	logic          status_q;
	logic [10:0]   where_q;
	logic          out_valid_q;
	logic          out_status_q;
	logic [10:0]   out_unit_q;
	logic [11:0]   out_left_q;

	// RAM ports
	logic          we;
	logic [AW-1:0] waddr;
	logic [WW-1:0] wdata;
	xaddr_t        raddr_x;
	logic [WW-1:0] rd_data;
	logic [WW-1:0] rd_word;
	xaddr_t        wa1;
	xaddr_t        after;
	logic [13:0]   units_sum;
	logic [12:0]   units_in;
	logic [SW-1:0] bu_sum;

	// next link decode: corrupt or missing links read as the end marker
	function automatic logic [CW-1:0] next_of(logic neg, logic [WW-1:0] raw, xaddr_t s);
		logic bad;
		bad = neg || (SW'(raw) <= SW'(s)) || (SW'(raw) > SW'(ARENA_UNITS));
		return bad ? CW'(ARENA_UNITS) : raw[CW-1:0];
	endfunction

	ffua_ram #(
		.WIDTH (WW),
		.DEPTH (ARENA_UNITS)
	) u_hdr (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr_x[AW-1:0]),
		.rdata (rd_data)
	);

	// read address: word s+1 is requested while word s is decoded
	assign raddr_x = (cmd == C_W0) ? cur_q + xaddr_t'(1) : cur_q;
	assign rd_word = rd_oob_q ? '0 : rd_data;
	assign wa1     = ws_addr_q + xaddr_t'(1);

	// write port: clearing sweep and block stores, out-of-arena writes dropped
	always_comb begin
		we    = 1'b0;
		waddr = ws_addr_q[AW-1:0];
		wdata = '0;
		case (cmd)
			C_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = (clr_q < AW'(2)) ? WW'(ARENA_UNITS) : '0;
			end
			C_WR_A: begin
				we    = ws_addr_q < END_X;
				waddr = ws_addr_q[AW-1:0];
				wdata = st.ws_big ? ws_size_q[WW-1:0] : (WW'(0) - WW'(ws_next_q));
			end
			C_WR_B: begin
				we    = wa1 < END_X;
				waddr = wa1[AW-1:0];
				wdata = WW'(ws_next_q);
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// byte size to units, zero counts as one unit
	assign units_sum = 14'(in_size) + 14'd1;
	assign units_in  = (in_size == '0) ? 13'd1 : units_sum[13:1];
	assign bu_sum    = SW'(b_q) + SW'(units_q);
	assign after     = st.exact ? xaddr_t'(fn_q) : cur_q + xaddr_t'(units_q);

	// status toward the controller
	always_comb begin
		st.clr_done   = clr_q == AW'(ARENA_UNITS - 1);
		st.is_free    = op_q;
		// word s not negative: the next link sits in word s+1
		st.w0_pos     = !rd_word[WW-1];
		st.a_nofit    = (SW'(count_q) < SW'(units_q)) || (head_q >= END_X);
		st.fit        = SW'(fu_q) >= SW'(units_q);
		st.exact      = SW'(fu_q) == SW'(units_q);
		st.fn_end     = fn_q >= CW'(ARENA_UNITS);
		st.has_prev   = has_prev_q;
		st.whole      = (SW'(count_q) + SW'(units_q)) >= SW'(ARENA_UNITS);
		st.b_lt_head  = SW'(b_q) < SW'(head_q);
		st.head_merge = (head_q < END_X) && (bu_sum == SW'(head_q));
		st.b_gt_fn    = SW'(b_q) > SW'(fn_q);
		st.next_merge = (fn_q < CW'(ARENA_UNITS)) && (bu_sum == SW'(fn_q));
		st.prev_adj   = (SW'(prev_q) + SW'(fu_q)) == SW'(b_q);
		st.ws_big     = ws_size_q > SW'(1);
		st.out_free   = !out_valid_q || out_ready;
	end

	// control registers: list head, free count, sweep, predecessor flag, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= CW'(ARENA_UNITS);
			clr_q       <= '0;
			has_prev_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (cmd == C_PUSH) || (out_valid_q && !out_ready);
			case (cmd)
				C_CLEAR:     clr_q <= clr_q + AW'(1);
				C_A_START:   has_prev_q <= 1'b0;
				C_A_STEP:    has_prev_q <= 1'b1;
				C_A_HIT: begin
					if (!has_prev_q) begin
						head_q <= after;
					end
					count_q <= count_q - CW'(units_q);
				end
				C_WHOLE: begin
					head_q  <= '0;
					count_q <= CW'(ARENA_UNITS);
				end
				C_F_START:   count_q <= count_q + CW'(units_q);
				C_FH_MERGE:  head_q <= xaddr_t'(b_q);
				C_FH_PLAIN:  head_q <= xaddr_t'(b_q);
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		rd_oob_q <= raddr_x >= END_X;
		case (cmd)
			C_LOAD: begin
				op_q     <= in_op;
				units_q  <= units_in;
				b_q      <= in_block;
				status_q <= 1'b0;
				where_q  <= '0;
			end
			C_W0: begin
				if (st.w0_pos) begin
					fu_q <= (rd_word == '0) ? 15'd1 : rd_word[14:0];
				end else begin
					fu_q <= 15'd1;
					fn_q <= next_of(1'b0, WW'(0) - rd_word, cur_q);
				end
			end
			C_W1:        fn_q <= next_of(rd_word[WW-1], rd_word, cur_q);
			C_A_START:   cur_q <= head_q;
			C_A_STEP: begin
				prev_q <= cur_q[CW-1:0];
				pu_q   <= fu_q;
				cur_q  <= xaddr_t'(fn_q);
			end
			C_A_HIT: begin
				ws_addr_q <= xaddr_t'(prev_q);
				ws_size_q <= SW'(pu_q);
				ws_next_q <= after;
				where_q   <= cur_q[10:0];
			end
			C_A_SPLIT: begin
				ws_addr_q <= cur_q + xaddr_t'(units_q);
				ws_size_q <= SW'(fu_q) - SW'(units_q);
				ws_next_q <= xaddr_t'(fn_q);
			end
			C_FAIL: begin
				status_q <= 1'b1;
				where_q  <= '0;
			end
			C_WHOLE: begin
				ws_addr_q <= '0;
				ws_size_q <= SW'(ARENA_UNITS);
				ws_next_q <= END_X;
			end
			C_F_START: begin
				size_q <= SW'(units_q);
				cur_q  <= head_q;
				prev_q <= head_q[CW-1:0];
			end
			C_FH_MERGE: begin
				ws_addr_q <= xaddr_t'(b_q);
				ws_size_q <= size_q + SW'(fu_q);
				ws_next_q <= xaddr_t'(fn_q);
			end
			C_FH_PLAIN: begin
				ws_addr_q <= xaddr_t'(b_q);
				ws_size_q <= size_q;
				ws_next_q <= head_q;
			end
			C_W_STEP: begin
				prev_q <= fn_q;
				cur_q  <= xaddr_t'(fn_q);
			end
			C_W_END: begin
				cur_q     <= xaddr_t'(fn_q);
				ws_addr_q <= xaddr_t'(b_q);
				ws_size_q <= size_q;
				ws_next_q <= xaddr_t'(fn_q);
			end
			C_N_MERGE: begin
				ws_addr_q <= xaddr_t'(b_q);
				ws_size_q <= size_q + SW'(fu_q);
				ws_next_q <= xaddr_t'(fn_q);
			end
			C_P_REFETCH: cur_q <= xaddr_t'(prev_q);
			C_P_SAVE: begin
				pu_q  <= fu_q;
				cur_q <= xaddr_t'(b_q);
			end
			C_P_MERGE: begin
				ws_addr_q <= xaddr_t'(prev_q);
				ws_size_q <= SW'(fu_q) + SW'(pu_q);
				ws_next_q <= xaddr_t'(fn_q);
			end
			C_P_PLAIN: begin
				ws_addr_q <= xaddr_t'(prev_q);
				ws_size_q <= SW'(fu_q);
				ws_next_q <= xaddr_t'(b_q);
			end
			C_PUSH: begin
				out_status_q <= status_q;
				out_unit_q   <= where_q;
				out_left_q   <= 12'(count_q);
			end
			default: begin
			end
		endcase
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_unit   = out_unit_q;
	assign out_left   = out_left_q;

	`FFUA_ALWAYS(a_count_range, count_q <= CW'(ARENA_UNITS))
	`FFUA_NEXT(a_push_valid, cmd == C_PUSH, out_valid_q)
	`FFUA_NEXT(a_result_holds, out_valid_q && !out_ready, out_valid_q)

endmodule

FILE: sim/tb_first_fit_unit_allocator.sv
// ----------------------------------------------------------------------------
// tb_first_fit_unit_allocator
// Self-checking bench: a directed table, then random alloc/free traffic with
// idle and stall gaps on both streams. Each result beat is compared against
// its typed row or the in-bench address-ordered first-fit list model.
// ----------------------------------------------------------------------------
module tb_first_fit_unit_allocator;
	import ffua_pkg::*;

	typedef enum bit {OP_ALLOC = 1'b0, OP_FREE = 1'b1} op_e;
	typedef enum bit {ST_DONE = 1'b0, ST_NOFIT = 1'b1} status_e;

	typedef struct {
		op_e        op;
		logic [12:0] size_bytes;
		logic [10:0] block_unit;
	} req_t;

	typedef struct {
		status_e     status;
		logic [10:0] alloc_unit;
		logic [11:0] units_left;
	} rsp_t;

	typedef struct {
		op_e         op;
		int          size_bytes;
		int          block_unit;
		bit          typed;
		rsp_t        rsp;
	} row_t;

	typedef struct {
		int unit_ofs;
		int units;
	} live_t;

	localparam int CYCLE_LIMIT = 4000000;
	localparam int N_RANDOM    = 2000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic [0:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic [0:0]  m_tuser;

	// shadow of the allocator state
	logic [15:0] arena_words [ARENA_UNITS];
	int          free_start;
	int          units_free;

	rsp_t  pending_rsp[$];
	live_t live_blocks[$];
	int    mismatches;
	int    cycles;
	bit    quiet;

	first_fit_unit_allocator dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ---------------- list model ----------------
	function automatic int word_at(int i);
		if (i >= ARENA_UNITS || i < 0)
			return 0;
		return arena_words[i][15] ? int'(arena_words[i]) - 65536 : int'(arena_words[i]);
	endfunction

	function automatic void word_put(int i, int v);
		if (i < ARENA_UNITS && i >= 0)
			arena_words[i] = v[15:0];
	endfunction

	function automatic int span_of(int s);
		int v;
		v = word_at(s);
		return v > 0 ? v : 1;
	endfunction

	function automatic int link_of(int s);
		int v, raw;
		v = word_at(s);
		raw = v < 0 ? -v : word_at(s + 1);
		if (raw <= s || raw > ARENA_UNITS)
			return ARENA_UNITS;
		return raw;
	endfunction

	function automatic void block_put(int s, int span, int link);
		if (span > 1) begin
			word_put(s, span);
			word_put(s + 1, link);
		end else begin
			word_put(s, 65536 - (link & 16'hFFFF));
		end
	endfunction

	function automatic void arena_reclaim();
		word_put(0, ARENA_UNITS);
		word_put(1, ARENA_UNITS);
		free_start = 0;
		units_free = ARENA_UNITS;
		live_blocks.delete();
	endfunction

	function automatic bit first_fit(int units, output int at);
		int cur, prv, avail, nxt, after;
		bit has_prv;
		cur = free_start;
		prv = 0;
		has_prv = 0;
		at = 0;
		if (units_free < units || free_start >= ARENA_UNITS)
			return 0;
		while (cur < ARENA_UNITS) begin
			avail = span_of(cur);
			nxt = link_of(cur);
			if (avail >= units) begin
				after = (avail == units) ? nxt : cur + units;
				if (has_prv)
					block_put(prv, span_of(prv), after);
				else
					free_start = after;
				if (avail != units)
					block_put(cur + units, avail - units, nxt);
				units_free -= units;
				at = cur;
				return 1;
			end
			prv = cur;
			has_prv = 1;
			cur = nxt;
		end
		return 0;
	endfunction

	function automatic void give_back(int b, int units);
		int span, prv, nxt, hd;
		span = units;
		if (units_free + units >= ARENA_UNITS) begin
			arena_reclaim();
			return;
		end
		units_free += units;
		if (b < free_start) begin
			hd = free_start;
			// block ends right at the head: absorb it
			if (hd < ARENA_UNITS && b + units == hd) begin
				span += span_of(hd);
				hd = link_of(hd);
			end
			block_put(b, span, hd);
			free_start = b;
			return;
		end
		prv = free_start;
		nxt = link_of(prv);
		while (b > nxt) begin
			prv = nxt;
			nxt = link_of(prv);
		end
		if (nxt < ARENA_UNITS && b + units == nxt) begin
			span += span_of(nxt);
			block_put(b, span, link_of(nxt));
		end else begin
			block_put(b, span, nxt);
		end
		if (prv + span_of(prv) == b)
			block_put(prv, span_of(b) + span_of(prv), link_of(b));
		else
			block_put(prv, span_of(prv), b);
	endfunction

	function automatic rsp_t allocator_step(req_t r);
		rsp_t o;
		int units, at;
		units = (int'(r.size_bytes) + 1) >> 1;
		if (units == 0)
			units = 1;
		o.status = ST_DONE;
		o.alloc_unit = '0;
		if (r.op == OP_ALLOC) begin
			if (first_fit(units, at)) begin
				o.alloc_unit = at[10:0];
				live_blocks.push_back('{at, units});
			end else begin
				o.status = ST_NOFIT;
			end
		end else if (int'(r.block_unit) < ARENA_UNITS) begin
			give_back(int'(r.block_unit), units);
		end
		o.units_left = units_free[11:0];
		return o;
	endfunction

	// ---------------- stimulus ----------------
	function automatic bit gap();
		return !quiet && ($urandom_range(99) < 10);
	endfunction

	task automatic send_beat(req_t r, bit typed, rsp_t typed_rsp);
		rsp_t got;
		while (gap()) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {r.block_unit, r.size_bytes};
		s_tuser  <= r.op;
		do
			@(posedge clk);
		while (!s_tready);
		got = allocator_step(r);
		pending_rsp.push_back(typed ? typed_rsp : got);
	endtask

	function automatic req_t random_req();
		req_t r;
		int k, pick, units, roll;
		roll = $urandom_range(99);
		r.block_unit = $urandom_range(2047);
		if (roll < 5) begin
			// stray free: double, overlapping or arbitrary
			r.op = OP_FREE;
			r.size_bytes = $urandom_range(8191);
		end else if (roll < 45 && live_blocks.size() > 0) begin
			r.op = OP_FREE;
			pick = $urandom_range(live_blocks.size() - 1);
			units = live_blocks[pick].units;
			r.block_unit = live_blocks[pick].unit_ofs;
			r.size_bytes = 2 * units - $urandom_range(1);
			live_blocks.delete(pick);
		end else begin
			r.op = OP_ALLOC;
			k = $urandom_range(99);
			r.size_bytes = (k < 3) ? $urandom_range(8191) :
				(k < 15) ? $urandom_range(512) : $urandom_range(64);
		end
		return r;
	endfunction

	// directed table; typed rows carry their expected beat
	row_t plan[] = '{
		'{OP_ALLOC, 1,    0,    1, '{ST_DONE,  11'd0, 12'd2047}},
		'{OP_ALLOC, 0,    0,    1, '{ST_DONE,  11'd1, 12'd2046}},
		'{OP_FREE,  1,    0,    1, '{ST_DONE,  11'd0, 12'd2047}},
		'{OP_ALLOC, 4096, 0,    1, '{ST_NOFIT, 11'd0, 12'd2047}},
		'{OP_ALLOC, 8191, 0,    1, '{ST_NOFIT, 11'd0, 12'd2047}},
		'{OP_FREE,  0,    1,    1, '{ST_DONE,  11'd0, 12'd2048}},
		'{OP_ALLOC, 4096, 0,    1, '{ST_DONE,  11'd0, 12'd0}},
		'{OP_ALLOC, 1,    0,    1, '{ST_NOFIT, 11'd0, 12'd0}},
		'{OP_FREE,  4096, 0,    1, '{ST_DONE,  11'd0, 12'd2048}},
		'{OP_ALLOC, 10,   0,    0, '{ST_DONE, 0, 0}},
		'{OP_ALLOC, 20,   0,    0, '{ST_DONE, 0, 0}},
		'{OP_ALLOC, 30,   0,    0, '{ST_DONE, 0, 0}},
		'{OP_FREE,  10,   0,    0, '{ST_DONE, 0, 0}},
		'{OP_FREE,  29,   15,   0, '{ST_DONE, 0, 0}},
		'{OP_FREE,  20,   5,    0, '{ST_DONE, 0, 0}},
		'{OP_ALLOC, 6,    0,    0, '{ST_DONE, 0, 0}},
		'{OP_ALLOC, 5,    0,    0, '{ST_DONE, 0, 0}},
		'{OP_ALLOC, 2,    0,    0, '{ST_DONE, 0, 0}},
		'{OP_FREE,  6,    3,    0, '{ST_DONE, 0, 0}},
		'{OP_FREE,  6,    3,    0, '{ST_DONE, 0, 0}},
		'{OP_FREE,  8191, 2047, 0, '{ST_DONE, 0, 0}},
		'{OP_FREE,  2,    1024, 0, '{ST_DONE, 0, 0}}
	};

	// ---------------- result checker ----------------
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat %h/%h", m_tuser, m_tdata);
			end else begin
				want = pending_rsp.pop_front();
				if (m_tuser[0] !== want.status || m_tdata[10:0] !== want.alloc_unit ||
				    m_tdata[22:11] !== want.units_left || m_tdata[23] !== 1'b0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp st=%0d at=%0d left=%0d, got st=%0d at=%0d left=%0d",
							want.status, want.alloc_unit, want.units_left,
							m_tuser[0], m_tdata[10:0], m_tdata[22:11]);
				end
			end
		end
	end

	// result-side backpressure
	always @(negedge clk)
		m_tready <= !gap();

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("first_fit_unit_allocator regression: fail");
			$finish;
		end
	end

	// ---------------- main sequence ----------------
	initial begin
		req_t r;
		rsp_t none;
		int wait_cnt;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		mismatches = 0;
		cycles = 0;
		quiet = 0;
		none = '{ST_DONE, 11'd0, 12'd0};
		for (int i = 0; i < ARENA_UNITS; i++)
			arena_words[i] = '0;
		arena_reclaim();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (plan[i]) begin
			r.op = plan[i].op;
			r.size_bytes = plan[i].size_bytes;
			r.block_unit = plan[i].block_unit;
			send_beat(r, plan[i].typed, plan[i].rsp);
		end

		for (int n = 0; n < N_RANDOM; n++) begin
			// a long stretch with both sides running flat out
			quiet = (n >= 600 && n < 1000);
			r = random_req();
			send_beat(r, 0, none);
		end
		quiet = 0;
		@(negedge clk);
		s_tvalid <= 1'b0;

		while (pending_rsp.size() != 0)
			@(posedge clk);
		wait_cnt = 0;
		while (wait_cnt < 200) begin
			@(posedge clk);
			wait_cnt++;
		end
		if (mismatches == 0 && pending_rsp.size() == 0)
			$display("first_fit_unit_allocator regression: pass");
		else
			$display("first_fit_unit_allocator regression: fail");
		$finish;
	end

endmodule

FILE: first_fit_unit_allocator.f
+incdir+rtl/core
rtl/core/ffua_pkg.sv
rtl/core/ffua_ram.sv
rtl/core/ffua_ctrl.sv
rtl/core/ffua_dp.sv
rtl/core/first_fit_unit_allocator.sv
sim/tb_first_fit_unit_allocator.sv
